// ===== hdl/trsd_pkg.sv =====
// Shared types and constants for the token record stream decoder.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package trsd_pkg;

   // decoder phases; every phase up to PH_STR_V doubles as a result role
   localparam logic [3:0] PH_MAGIC = 4'd0;
   localparam logic [3:0] PH_COUNT = 4'd1;
   localparam logic [3:0] PH_TYPE  = 4'd2;
   localparam logic [3:0] PH_DEPTH = 4'd3;
   localparam logic [3:0] PH_LEN_P = 4'd4;
   localparam logic [3:0] PH_STR_P = 4'd5;
   localparam logic [3:0] PH_LEN_N = 4'd6;
   localparam logic [3:0] PH_STR_N = 4'd7;
   localparam logic [3:0] PH_LEN_V = 4'd8;
   localparam logic [3:0] PH_STR_V = 4'd9;
   localparam logic [3:0] PH_DONE  = 4'd10;

   localparam logic [3:0] ROLE_IGNORED = 4'd10;

   // buffer status codes, also used as the sticky error code
   localparam logic [2:0] ST_RUNNING   = 3'd0;
   localparam logic [2:0] ST_OK        = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd4;
   localparam logic [2:0] ST_TRAILING  = 3'd5;

   localparam logic [2:0] MAGIC_LEN = 3'd5;

   // token type byte range
   localparam logic [7:0] TYPE_MIN = 8'd1;
   localparam logic [7:0] TYPE_MAX = 8'd4;

   // one result item
   typedef struct packed {
      logic [3:0]  role;
      logic [7:0]  data_byte;
      logic [1:0]  token_kind;
      logic [31:0] token_index;
      logic [31:0] depth_value;
      logic        token_end;
      logic        done_res;
      logic [2:0]  status;
   } rsp_item_type;

   // expected header byte at a given position (position taken modulo five)
   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] val;
      case (pos)
         3'd0:    val = 8'h50; // P
         3'd1:    val = 8'h56; // V
         3'd2:    val = 8'h54; // T
         3'd3:    val = 8'h44; // D
         3'd4:    val = 8'h31; // 1
         3'd5:    val = 8'h50;
         3'd6:    val = 8'h56;
         default: val = 8'h54;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/trsd_if.sv =====
// Valid/ready channel interfaces for the token record stream decoder.
// Depends on nothing; the top level uses both.
`timescale 1ns / 1ps
`default_nettype none

// input channel: one buffer byte per item
interface trsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// result channel: one tagged byte per item
interface trsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  role;
   logic [7:0]  data_byte;
   logic [1:0]  token_kind;
   logic [31:0] token_index;
   logic [31:0] depth_value;
   logic        token_end;
   logic        done_res;
   logic [2:0]  status;

   modport source (output valid, output role, output data_byte, output token_kind,
                   output token_index, output depth_value, output token_end,
                   output done_res, output status, input ready);
   modport sink   (input valid, input role, input data_byte, input token_kind,
                   input token_index, input depth_value, input token_end,
                   input done_res, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/token_record_stream_decoder_unit.sv =====
// Token record stream decoder: top level.
// Depends on trsd_pkg and the channel interfaces in trsd_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req_chan carries one byte of a serialized token buffer per item, with
//   last_byte marking the final byte. rsp_chan returns exactly one item per
//   input byte: the byte, its role, the current token kind, index and depth,
//   a token-complete flag, and on the last byte the buffer status.
//   Tags are tentative: software drops the whole buffer unless the status
//   on the last byte is ok.
// Timing
//   An accepted item is captured in the input register, then decoded and
//   written to the result register once that register is empty or being
//   taken by the receiver; its result is offered from there. One item per
//   cycle is sustained while rsp_chan.ready stays high; the single decode
//   stage between the two registers sets it.
// Reset and stalls
//   reset empties both registers and returns the decoder to the header
//   phase. When the receiver holds rsp_chan.ready low, the result stays put,
//   the input register holds its byte, and req_chan.ready falls only once
//   both are full. The last byte of a buffer restores the reset state, so the next byte opens a new buffer.
module token_record_stream_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   trsd_req_if.sink         req_chan,
   trsd_rsp_if.source       rsp_chan
);

   // pipeline registers
   logic                         in_valid_ff;
   logic [7:0]                   in_byte_ff;
   logic                         in_last_ff;
   logic                         out_valid_ff;
   trsd_pkg::rsp_item_type       out_ff;
   trsd_pkg::rsp_item_type       out_in;

   // decoder state
   logic [3:0]  phase_ff,    phase_in;
   logic [2:0]  fbc_ff,      fbc_in;
   logic [31:0] word_ff,     word_in;
   logic [31:0] str_rem_ff,  str_rem_in;
   logic [31:0] tok_rem_ff,  tok_rem_in;
   logic [31:0] tok_cnt_ff,  tok_cnt_in;
   logic [1:0]  kind_ff,     kind_in;
   logic [31:0] depth_ff,    depth_in;
   logic [2:0]  err_ff,      err_in;

   // handshake
   logic advance;
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // helper values for the decode step
   logic [31:0] word_or;
   logic [2:0]  count_inc;
   logic        word_done;
   logic [31:0] str_dec;
   logic [31:0] tok_dec;
   logic        str_end;
   logic [3:0]  str_phase;
   logic        tend;
   logic [2:0]  status;

   assign word_or   = word_ff | ({24'd0, in_byte_ff} << {fbc_ff[1:0], 3'b000});
   assign count_inc = fbc_ff + 3'd1;
   assign word_done = count_inc[2];
   assign str_dec   = str_rem_ff - 32'd1;
   assign tok_dec   = tok_rem_ff - 32'd1;

   // decode one byte against the current state
   always_comb begin
      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      word_in    = word_ff;
      str_rem_in = str_rem_ff;
      tok_rem_in = tok_rem_ff;
      tok_cnt_in = tok_cnt_ff;
      kind_in    = kind_ff;
      depth_in   = depth_ff;
      err_in     = err_ff;
      tend       = 1'b0;
      str_end    = 1'b0;
      str_phase  = phase_ff;
      status     = trsd_pkg::ST_RUNNING;

      if (err_ff == trsd_pkg::ST_RUNNING) begin
         case (phase_ff)
            trsd_pkg::PH_MAGIC: begin
               if (in_byte_ff != trsd_pkg::magic_byte(fbc_ff)) begin
                  err_in = trsd_pkg::ST_BAD_MAGIC;
               end else begin
                  fbc_in = count_inc;
                  if (count_inc >= trsd_pkg::MAGIC_LEN) begin
                     fbc_in   = 3'd0;
                     word_in  = 32'd0;
                     phase_in = trsd_pkg::PH_COUNT;
                  end
               end
            end
            trsd_pkg::PH_COUNT: begin
               word_in = word_or;
               fbc_in  = count_inc;
               if (word_done) begin
                  fbc_in     = 3'd0;
                  word_in    = 32'd0;
                  tok_rem_in = word_or;
                  phase_in   = (word_or != 32'd0) ? trsd_pkg::PH_TYPE : trsd_pkg::PH_DONE;
               end
            end
            trsd_pkg::PH_TYPE: begin
               if (in_byte_ff >= trsd_pkg::TYPE_MIN && in_byte_ff <= trsd_pkg::TYPE_MAX) begin
                  kind_in  = in_byte_ff[1:0] - 2'd1;
                  depth_in = 32'd0;
                  fbc_in   = 3'd0;
                  word_in  = 32'd0;
                  phase_in = trsd_pkg::PH_DEPTH;
               end else begin
                  kind_in = 2'd0;
                  err_in  = trsd_pkg::ST_BAD_TYPE;
               end
            end
            trsd_pkg::PH_DEPTH: begin
               word_in = word_or;
               fbc_in  = count_inc;
               if (word_done) begin
                  fbc_in   = 3'd0;
                  word_in  = 32'd0;
                  depth_in = word_or;
                  phase_in = trsd_pkg::PH_LEN_P;
               end
            end
            trsd_pkg::PH_LEN_P, trsd_pkg::PH_LEN_N, trsd_pkg::PH_LEN_V: begin
               word_in = word_or;
               fbc_in  = count_inc;
               if (word_done) begin
                  fbc_in  = 3'd0;
                  word_in = 32'd0;
                  if (word_or == 32'd0) begin
                     // empty string: skip its byte phase
                     str_end   = 1'b1;
                     str_phase = phase_ff + 4'd1;
                  end else begin
                     str_rem_in = word_or;
                     phase_in   = phase_ff + 4'd1;
                  end
               end
            end
            trsd_pkg::PH_STR_P, trsd_pkg::PH_STR_N, trsd_pkg::PH_STR_V: begin
               str_rem_in = str_dec;
               if (str_dec == 32'd0) begin
                  str_end   = 1'b1;
                  str_phase = phase_ff;
               end
            end
            default: begin
               // a byte after the last token
               err_in = trsd_pkg::ST_TRAILING;
            end
         endcase

         // end of a string: next string, or close the token
         if (str_end) begin
            if (str_phase >= trsd_pkg::PH_STR_V) begin
               tend       = 1'b1;
               tok_cnt_in = tok_cnt_ff + 32'd1;
               tok_rem_in = tok_dec;
               phase_in   = (tok_dec != 32'd0) ? trsd_pkg::PH_TYPE : trsd_pkg::PH_DONE;
            end else begin
               phase_in = str_phase + 4'd1;
            end
         end
      end

      // final status on the last byte
      if (in_last_ff) begin
         if (err_in != trsd_pkg::ST_RUNNING) begin
            status = err_in;
         end else begin
            status = (phase_in == trsd_pkg::PH_DONE) ? trsd_pkg::ST_OK
                                                     : trsd_pkg::ST_TRUNCATED;
         end
      end

      // result item
      out_in.role        = (err_ff != trsd_pkg::ST_RUNNING || phase_ff > trsd_pkg::PH_STR_V)
                           ? trsd_pkg::ROLE_IGNORED : phase_ff;
      out_in.data_byte   = in_byte_ff;
      out_in.token_kind  = kind_in;
      out_in.token_index = tok_cnt_ff;
      out_in.depth_value = depth_in;
      out_in.token_end   = tend;
      out_in.done_res    = in_last_ff;
      out_in.status      = status;

      // the last byte returns everything to the start of a buffer
      if (in_last_ff) begin
         phase_in   = trsd_pkg::PH_MAGIC;
         fbc_in     = 3'd0;
         word_in    = 32'd0;
         str_rem_in = 32'd0;
         tok_rem_in = 32'd0;
         tok_cnt_in = 32'd0;
         kind_in    = 2'd0;
         depth_in   = 32'd0;
         err_in     = trsd_pkg::ST_RUNNING;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.byte_value;
         in_last_ff <= req_chan.last_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // decoder state, updated as each item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= trsd_pkg::PH_MAGIC;
         fbc_ff     <= 3'd0;
         word_ff    <= 32'd0;
         str_rem_ff <= 32'd0;
         tok_rem_ff <= 32'd0;
         tok_cnt_ff <= 32'd0;
         kind_ff    <= 2'd0;
         depth_ff   <= 32'd0;
         err_ff     <= trsd_pkg::ST_RUNNING;
      end else if (advance) begin
         phase_ff   <= phase_in;
         fbc_ff     <= fbc_in;
         word_ff    <= word_in;
         str_rem_ff <= str_rem_in;
         tok_rem_ff <= tok_rem_in;
         tok_cnt_ff <= tok_cnt_in;
         kind_ff    <= kind_in;
         depth_ff   <= depth_in;
         err_ff     <= err_in;
      end
   end

   // result channel outputs
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.role        = out_ff.role;
   assign rsp_chan.data_byte   = out_ff.data_byte;
   assign rsp_chan.token_kind  = out_ff.token_kind;
   assign rsp_chan.token_index = out_ff.token_index;
   assign rsp_chan.depth_value = out_ff.depth_value;
   assign rsp_chan.token_end   = out_ff.token_end;
   assign rsp_chan.done_res    = out_ff.done_res;
   assign rsp_chan.status      = out_ff.status;

endmodule

`default_nettype wire
